// ----- rtl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// clocked assertion helpers, sampled on i_clk and disabled while in reset
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define CHK_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define CHK_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/chtl_pkg.sv -----
// ----------------------------------------------------------------------------
// chtl_pkg
// shared types and constants of the chained hash table lookup core
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package chtl_pkg;

    localparam int LETTER_W    = 5;
    localparam int DIGIT_W     = 4;
    localparam int ITEM_NUM_W  = 16;
    localparam int DIV_W       = 7;
    localparam int CODE_W      = 14;
    localparam int CNT_W       = 4;
    localparam int OUT_NUM_W   = 16;
    localparam int BKT_OUT_W   = 6;
    localparam int LETTER_SPAN = 26;
    localparam int DIGIT_SPAN  = 10;
    localparam int TS_RESET    = 64;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_SEARCH = 1'b1;

    typedef enum logic [2:0] {
        ST_INSERTED  = 3'd0,
        ST_DUPLICATE = 3'd1,
        ST_FULL      = 3'd2,
        ST_FOUND     = 3'd3,
        ST_NOT_FOUND = 3'd4
    } t_status;

    typedef struct packed {
        logic [LETTER_W-1:0] first;
        logic [LETTER_W-1:0] second;
        logic [DIGIT_W-1:0]  digit;
    } t_key;

    localparam int KEY_W = $bits(t_key);

    typedef struct packed {
        logic busy;
        logic done;
    } t_mod_status;

    function automatic logic [CODE_W-1:0] key_code(input t_key k);
        key_code = CODE_W'(k.first) * CODE_W'(LETTER_SPAN * DIGIT_SPAN)
                 + CODE_W'(k.second) * CODE_W'(DIGIT_SPAN)
                 + CODE_W'(k.digit);
    endfunction

endpackage

// ----- rtl/chtl_mod_unit.sv -----
// ----------------------------------------------------------------------------
// chtl_mod_unit
// restoring remainder unit, one code bit per cycle through one subtractor
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module chtl_mod_unit (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [chtl_pkg::CODE_W-1:0] i_code,
    input  logic [chtl_pkg::DIV_W-1:0]  i_divisor,
    output chtl_pkg::t_mod_status       o_status,
    output logic [chtl_pkg::DIV_W-1:0]  o_rem
);
    import chtl_pkg::*;

    logic              r_busy;
    logic              r_done;
    logic [CNT_W-1:0]  r_cnt;
    logic [CODE_W-1:0] r_code;
    logic [DIV_W-1:0]  r_div;
    logic [DIV_W-1:0]  r_rem;
    logic [DIV_W-1:0]  n_rem;
    logic [DIV_W:0]    w_shift;
    logic [DIV_W+1:0]  w_trial;

    always_comb begin
        w_shift = {r_rem, r_code[CODE_W-1]};
        w_trial = {1'b0, w_shift} - {2'b00, r_div};
        if (w_trial[DIV_W+1]) begin
            n_rem = w_shift[DIV_W-1:0];
        end else begin
            n_rem = w_trial[DIV_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_code <= i_code;
                r_div  <= i_divisor;
                r_rem  <= '0;
            end else if (r_busy) begin
                r_rem  <= n_rem;
                r_code <= {r_code[CODE_W-2:0], 1'b0};
                r_cnt  <= r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(CODE_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_status.busy = r_busy;
    assign o_status.done = r_done;
    assign o_rem         = r_rem;

endmodule

// ----- rtl/chtl_entry_store.sv -----
// ----------------------------------------------------------------------------
// chtl_entry_store
// simple dual-port entry memory, one write and one registered read per cycle
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module chtl_entry_store #(
    parameter int NUM_ENTRIES  = 256,
    parameter int ADDR_W       = 8,
    parameter int NUMBER_WIDTH = 16
) (
    input  logic                    i_clk,
    input  logic                    i_we,
    input  logic [ADDR_W-1:0]       i_waddr,
    input  logic                    i_wvalid,
    input  chtl_pkg::t_key          i_wkey,
    input  logic [NUMBER_WIDTH-1:0] i_wnum,
    input  logic [ADDR_W-1:0]       i_raddr,
    output logic                    o_rvalid,
    output chtl_pkg::t_key          o_rkey,
    output logic [NUMBER_WIDTH-1:0] o_rnum
);
    import chtl_pkg::*;

    localparam int WORD_W = 1 + KEY_W + NUMBER_WIDTH;

    logic [WORD_W-1:0] r_mem [NUM_ENTRIES];
    logic [WORD_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= {i_wvalid, i_wkey, i_wnum};
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign {o_rvalid, o_rkey, o_rnum} = r_rdata;

endmodule

// ----- rtl/chained_hash_table_lookup_core.sv -----
// throughput: one request at a time, a new beat taken the cycle after the result loads
// the remainder unit resolves one key code bit per cycle, then each slot
// of the bucket, up to the first match, takes a memory read and a check
// reset: synchronous; the entry store is then cleared one entry per cycle over all
// NUM_BUCKETS*BUCKET_DEPTH entries, with input stalled and config writes still taken
// ----------------------------------------------------------------------------
// chained_hash_table_lookup_core
// bounded-chain hash table: insert and search of three-character keys
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module chained_hash_table_lookup_core #(
    parameter int NUM_BUCKETS  = 64,
    parameter int BUCKET_DEPTH = 4,
    parameter int NUMBER_WIDTH = 16
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_cfg_we,
    input  logic [chtl_pkg::DIV_W-1:0]            i_cfg_data,
    input  logic                                  i_in_valid,
    output logic                                  o_in_stall,
    input  logic                                  i_op,
    input  logic [chtl_pkg::LETTER_W-1:0]         i_key_first_letter,
    input  logic [chtl_pkg::LETTER_W-1:0]         i_key_second_letter,
    input  logic [chtl_pkg::DIGIT_W-1:0]          i_key_digit,
    input  logic [chtl_pkg::ITEM_NUM_W-1:0]       i_item_number,
    output logic                                  o_out_valid,
    input  logic                                  i_out_stall,
    output logic [2:0]                            o_status,
    output logic [chtl_pkg::BKT_OUT_W-1:0]        o_bucket_index,
    output logic [chtl_pkg::OUT_NUM_W-1:0]        o_found_number
);
    import chtl_pkg::*;

    localparam int NUM_ENTRIES = NUM_BUCKETS * BUCKET_DEPTH;
    localparam int ADDR_W      = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1;
    localparam int SLOT_W      = (BUCKET_DEPTH > 1) ? $clog2(BUCKET_DEPTH) : 1;
    localparam int TS_INIT     = (TS_RESET > NUM_BUCKETS) ? NUM_BUCKETS : TS_RESET;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_DIV,
        S_RD,
        S_CHK,
        S_FIN
    } t_state;

    t_state                  r_state;
    logic [DIV_W-1:0]        r_table_size;
    logic [ADDR_W-1:0]       r_clr_addr;
    logic                    r_op;
    t_key                    r_key;
    logic [NUMBER_WIDTH-1:0] r_num;
    logic [DIV_W-1:0]        r_bucket;
    logic [ADDR_W-1:0]       r_base;
    logic [SLOT_W-1:0]       r_slot;
    logic                    r_hit;
    logic [NUMBER_WIDTH-1:0] r_hit_num;
    logic                    r_free_found;
    logic [SLOT_W-1:0]       r_free_slot;
    logic                    r_out_valid;
    t_status                 r_status;
    logic [BKT_OUT_W-1:0]    r_bucket_out;
    logic [OUT_NUM_W-1:0]    r_found_out;

    logic                    w_accept;
    logic                    w_fin_go;
    logic                    w_ins_ok;
    t_key                    w_in_key;
    t_mod_status             w_mod_st;
    logic [DIV_W-1:0]        w_rem;
    logic                    w_we;
    logic [ADDR_W-1:0]       w_waddr;
    logic                    w_wvalid;
    logic [ADDR_W-1:0]       w_raddr;
    logic                    w_rvalid;
    t_key                    w_rkey;
    logic [NUMBER_WIDTH-1:0] w_rnum;
    logic [DIV_W-1:0]        w_cfg_ts;
    t_status                 w_status;

    assign w_in_key.first  = i_key_first_letter;
    assign w_in_key.second = i_key_second_letter;
    assign w_in_key.digit  = i_key_digit;

    assign o_in_stall = (r_state != S_IDLE);
    assign w_accept   = i_in_valid && !o_in_stall;
    assign w_fin_go   = (r_state == S_FIN) && (!r_out_valid || !i_out_stall);
    assign w_ins_ok   = (r_op == OP_INSERT) && !r_hit && r_free_found;

    // clamp of the written table size
    always_comb begin
        if (i_cfg_data == '0) begin
            w_cfg_ts = DIV_W'(1);
        end else if (int'(i_cfg_data) > NUM_BUCKETS) begin
            w_cfg_ts = DIV_W'(NUM_BUCKETS);
        end else begin
            w_cfg_ts = i_cfg_data;
        end
    end

    always_comb begin
        if (r_op == OP_INSERT) begin
            if (r_hit) begin
                w_status = ST_DUPLICATE;
            end else if (!r_free_found) begin
                w_status = ST_FULL;
            end else begin
                w_status = ST_INSERTED;
            end
        end else begin
            w_status = r_hit ? ST_FOUND : ST_NOT_FOUND;
        end
    end

    // memory port control
    always_comb begin
        if (r_state == S_CLEAR) begin
            w_we     = 1'b1;
            w_waddr  = r_clr_addr;
            w_wvalid = 1'b0;
        end else begin
            w_we     = w_fin_go && w_ins_ok;
            w_waddr  = r_base + ADDR_W'(r_free_slot);
            w_wvalid = 1'b1;
        end
        w_raddr = r_base + ADDR_W'(r_slot);
    end

    chtl_mod_unit u_mod (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (w_accept),
        .i_code    (key_code(w_in_key)),
        .i_divisor (r_table_size),
        .o_status  (w_mod_st),
        .o_rem     (w_rem)
    );

    chtl_entry_store #(
        .NUM_ENTRIES  (NUM_ENTRIES),
        .ADDR_W       (ADDR_W),
        .NUMBER_WIDTH (NUMBER_WIDTH)
    ) u_store (
        .i_clk    (i_clk),
        .i_we     (w_we),
        .i_waddr  (w_waddr),
        .i_wvalid (w_wvalid),
        .i_wkey   (r_key),
        .i_wnum   (r_num),
        .i_raddr  (w_raddr),
        .o_rvalid (w_rvalid),
        .o_rkey   (w_rkey),
        .o_rnum   (w_rnum)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_CLEAR;
            r_table_size <= DIV_W'(TS_INIT);
            r_clr_addr   <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_table_size <= w_cfg_ts;
            end
            if (w_fin_go) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_CLEAR: begin
                    if (r_clr_addr == ADDR_W'(NUM_ENTRIES - 1)) begin
                        r_state <= S_IDLE;
                    end else begin
                        r_clr_addr <= r_clr_addr + ADDR_W'(1);
                    end
                end
                S_IDLE: begin
                    if (w_accept) begin
                        r_op    <= i_op;
                        r_key   <= w_in_key;
                        r_num   <= NUMBER_WIDTH'(i_item_number);
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    if (w_mod_st.done) begin
                        r_bucket     <= w_rem;
                        r_base       <= ADDR_W'(int'(w_rem) * BUCKET_DEPTH);
                        r_slot       <= '0;
                        r_hit        <= 1'b0;
                        r_free_found <= 1'b0;
                        r_free_slot  <= '0;
                        r_state      <= S_RD;
                    end
                end
                S_RD: begin
                    r_state <= S_CHK;
                end
                S_CHK: begin
                    if (w_rvalid && (w_rkey == r_key)) begin
                        r_hit     <= 1'b1;
                        r_hit_num <= w_rnum;
                        r_state   <= S_FIN;
                    end else begin
                        if (!w_rvalid && !r_free_found) begin
                            r_free_found <= 1'b1;
                            r_free_slot  <= r_slot;
                        end
                        if (r_slot == SLOT_W'(BUCKET_DEPTH - 1)) begin
                            r_state <= S_FIN;
                        end else begin
                            r_slot  <= r_slot + SLOT_W'(1);
                            r_state <= S_RD;
                        end
                    end
                end
                S_FIN: begin
                    if (w_fin_go) begin
                        r_status     <= w_status;
                        r_bucket_out <= r_bucket[BKT_OUT_W-1:0];
                        r_found_out  <= (r_op == OP_SEARCH && r_hit) ?
                                        OUT_NUM_W'(r_hit_num) : '0;
                        r_state      <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_status       = r_status;
    assign o_bucket_index = r_bucket_out;
    assign o_found_number = r_found_out;

    `CHK_NEXT(a_accept_starts_mod, w_accept, w_mod_st.busy && (r_state == S_DIV), "mod unit idle")
    `CHK_NOW(a_rem_in_range, w_mod_st.done, w_rem < r_table_size, "bucket outside table size")
    `CHK_NOW(a_write_only_insert, (r_state != S_CLEAR) && w_we, w_ins_ok, "write outside insert")
    `CHK_NOW(a_clear_blocks_input, r_state == S_CLEAR, o_in_stall, "input taken during store clear")

endmodule
